// ===== design/tun_pkg.sv =====
// package for triangle_unit_normal: widths
// no dependencies
package tun_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF = 14;
  localparam int unsigned OUT_WIDTH = 16;

endpackage

// ===== design/tun_if.sv =====
// valid/ready channel interfaces for triangle_unit_normal
// depends on tun_pkg
interface tun_in_if #(
  parameter int unsigned CW = tun_pkg::COORD_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [CW-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tun_out_if;
  logic valid;
  logic ready;
  logic signed [tun_pkg::OUT_WIDTH-1:0] norm_x, norm_y, norm_z;
  logic degenerate;
  modport source (output valid, norm_x, norm_y, norm_z, degenerate, input ready);
  modport sink (input valid, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface

// ===== design/tun_cross.sv =====
// cross product stages: edge differences, products, difference of products
// depends on tun_pkg
module tun_cross #(
  parameter int unsigned CW = tun_pkg::COORD_WIDTH_DEF,
  localparam int unsigned DW = CW + 1,
  localparam int unsigned NW = 2 * DW + 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [CW-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
  output logic out_valid,
  output logic signed [NW-1:0] nx, ny, nz
);
  logic v1, v2;
  logic signed [DW-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [2*DW-1:0] p0, p1, p2, p3, p4, p5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux <= DW'(b_x) - DW'(a_x);
      uy <= DW'(b_y) - DW'(a_y);
      uz <= DW'(b_z) - DW'(a_z);
      vx <= DW'(c_x) - DW'(a_x);
      vy <= DW'(c_y) - DW'(a_y);
      vz <= DW'(c_z) - DW'(a_z);
      p0 <= uy * vz;
      p1 <= uz * vy;
      p2 <= uz * vx;
      p3 <= ux * vz;
      p4 <= ux * vy;
      p5 <= uy * vx;
      nx <= NW'(p0) - NW'(p1);
      ny <= NW'(p2) - NW'(p3);
      nz <= NW'(p4) - NW'(p5);
    end
  end
endmodule

// ===== design/tun_sqsum.sv =====
// squares and sum of squares of the cross product
// no dependencies
module tun_sqsum #(
  parameter int unsigned NW = 35,
  localparam int unsigned MW = NW - 1,
  localparam int unsigned SW = 2 * MW + 2
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [NW-1:0] nx, ny, nz,
  output logic out_valid,
  output logic [SW-1:0] s,
  output logic signed [NW-1:0] ox, oy, oz
);
  logic v1;
  logic [MW-1:0] mx, my, mz;
  logic signed [NW-1:0] tx, ty, tz;
  logic [2*MW-1:0] qx, qy, qz;
  logic signed [NW-1:0] rx, ry, rz;
  logic v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      out_valid <= v1;
    end
  end

  // |n| fits in NW-1 bits since |n| <= 2^(2DW-1)
  always_ff @(posedge clk) begin
    if (en) begin
      mx <= MW'(nx[NW-1] ? -nx : nx);
      my <= MW'(ny[NW-1] ? -ny : ny);
      mz <= MW'(nz[NW-1] ? -nz : nz);
      tx <= nx;
      ty <= ny;
      tz <= nz;
      qx <= mx * mx;
      qy <= my * my;
      qz <= mz * mz;
      rx <= tx;
      ry <= ty;
      rz <= tz;
      s <= SW'(qx) + SW'(qy) + SW'(qz);
      ox <= rx;
      oy <= ry;
      oz <= rz;
    end
  end
endmodule

// ===== design/tun_isqrt.sv =====
// pipelined restoring integer square root, one result bit per stage
// no dependencies
module tun_isqrt #(
  parameter int unsigned SW = 70,
  parameter int unsigned NW = 35,
  localparam int unsigned RW = SW / 2
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [SW-1:0] s,
  input  logic signed [NW-1:0] nx, ny, nz,
  output logic out_valid,
  output logic [RW-1:0] root,
  output logic zero,
  output logic signed [NW-1:0] ox, oy, oz
);
  logic [RW:0] vld;
  logic [SW-1:0] rem [RW+1];
  logic [RW-1:0] rt [RW+1];
  logic [SW-1:0] rad [RW+1];
  logic signed [NW-1:0] px [RW+1], py [RW+1], pz [RW+1];
  logic zr [RW+1];

  always_comb begin
    vld[0] = in_valid;
    rem[0] = '0;
    rt[0] = '0;
    rad[0] = s;
    px[0] = nx;
    py[0] = ny;
    pz[0] = nz;
    zr[0] = (s == '0);
  end

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic [SW+1:0] r2, t;
    always_comb begin
      r2 = {rem[k], rad[k][SW-1:SW-2]};
      t = r2 - {(SW+2-RW-2)'(0), rt[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!t[SW+1]) begin
          rem[k+1] <= SW'(t);
          rt[k+1] <= {rt[k][RW-2:0], 1'b1};
        end else begin
          rem[k+1] <= SW'(r2);
          rt[k+1] <= {rt[k][RW-2:0], 1'b0};
        end
        rad[k+1] <= {rad[k][SW-3:0], 2'b00};
        px[k+1] <= px[k];
        py[k+1] <= py[k];
        pz[k+1] <= pz[k];
        zr[k+1] <= zr[k];
      end
    end
  end

  assign out_valid = vld[RW];
  assign root = rt[RW];
  assign zero = zr[RW];
  assign ox = px[RW];
  assign oy = py[RW];
  assign oz = pz[RW];
endmodule

// ===== design/tun_div.sv =====
// pipelined restoring divide of |n|*2^F by root, one quotient bit per stage
// depends on tun_pkg
module tun_div #(
  parameter int unsigned NW = 35,
  parameter int unsigned RW = 35,
  parameter int unsigned F = tun_pkg::FRAC_BITS_DEF,
  localparam int unsigned QW = F + 1,
  localparam int unsigned AW = NW + F
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [NW-1:0] n,
  input  logic [RW-1:0] d,
  input  logic zero,
  output logic out_valid,
  output logic [tun_pkg::OUT_WIDTH-1:0] q_out,
  output logic zero_out
);
  logic [QW:0] vld;
  logic [AW-1:0] num [QW+1];
  logic [QW-1:0] q [QW+1];
  logic [RW-1:0] dv [QW+1];
  logic ng [QW+1];
  logic zr [QW+1];
  logic [AW-1:0] mag;
  logic [QW-1:0] qfin;

  always_comb begin
    mag = AW'(n[NW-1] ? -n : n);
    vld[0] = in_valid;
    num[0] = mag << F;
    q[0] = '0;
    dv[0] = d;
    ng[0] = n[NW-1];
    zr[0] = zero;
  end

  for (genvar k = 0; k < QW; k++) begin : g_st
    localparam int unsigned SH = QW - 1 - k;
    logic [AW+QW-1:0] trial;
    always_comb trial = (AW+QW)'(dv[k]) << SH;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if ((AW+QW)'(num[k]) >= trial) begin
          num[k+1] <= num[k] - AW'(trial);
          q[k+1] <= q[k] | (QW'(1) << SH);
        end else begin
          num[k+1] <= num[k];
          q[k+1] <= q[k];
        end
        dv[k+1] <= dv[k];
        ng[k+1] <= ng[k];
        zr[k+1] <= zr[k];
      end
    end
  end

  always_comb begin
    qfin = zr[QW] ? '0 : q[QW];
    if (ng[QW]) begin
      q_out = tun_pkg::OUT_WIDTH'(-(AW'(qfin)));
    end else begin
      q_out = tun_pkg::OUT_WIDTH'(AW'(qfin));
    end
  end
  assign out_valid = vld[QW];
  assign zero_out = zr[QW];
endmodule

// ===== design/triangle_unit_normal.sv =====
// top level of triangle_unit_normal: cross product, sum of squares,
// square root and three dividers; depends on tun_pkg, tun_if and submodules
//
// usage: one triangle per transaction on the in channel (nine signed
// coordinates), one unit normal per transaction on the out channel
// (norm_x/y/z signed with NORMAL_FRAC_BITS fraction bits, degenerate flag).
// a zero cross product gives degenerate = 1 and a zero normal.
// throughput: one transaction per cycle while the receiver does not stall.
// pipeline: 3 cross stages + 3 sum stages + (2*COORD_WIDTH+3) root stages
// + (NORMAL_FRAC_BITS+1) divide stages + 1 output register.
// the depth is set by the bit-per-stage root and divide.
// the whole pipeline advances when the output register is empty or taken;
// a stall from the receiver holds every stage, so in.ready drops and
// nothing is lost or repeated.
// reset clears all stage valid bits; payload registers are not reset.
module triangle_unit_normal #(
  parameter int unsigned COORD_WIDTH = tun_pkg::COORD_WIDTH_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = tun_pkg::FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  tun_in_if.sink in,
  tun_out_if.source out
);
  localparam int unsigned NW = 2 * (COORD_WIDTH + 1) + 1;
  localparam int unsigned SW = 2 * (NW - 1) + 2;
  localparam int unsigned RW = SW / 2;
  localparam int unsigned W = tun_pkg::OUT_WIDTH;

  logic en;
  logic v_c, v_s, v_r, v_d;
  logic signed [NW-1:0] cx, cy, cz, sx, sy, sz, rx, ry, rz;
  logic [SW-1:0] s;
  logic [RW-1:0] root;
  logic zr, dz;
  logic [W-1:0] qx, qy, qz;
  logic vout;

  assign en = !vout || out.ready;
  assign in.ready = en;

  tun_cross #(.CW(COORD_WIDTH)) u_cross (
    .clk, .rst, .en, .in_valid(in.valid),
    .a_x(in.a_x), .a_y(in.a_y), .a_z(in.a_z),
    .b_x(in.b_x), .b_y(in.b_y), .b_z(in.b_z),
    .c_x(in.c_x), .c_y(in.c_y), .c_z(in.c_z),
    .out_valid(v_c), .nx(cx), .ny(cy), .nz(cz)
  );

  tun_sqsum #(.NW(NW)) u_sq (
    .clk, .rst, .en, .in_valid(v_c), .nx(cx), .ny(cy), .nz(cz),
    .out_valid(v_s), .s(s), .ox(sx), .oy(sy), .oz(sz)
  );

  tun_isqrt #(.SW(SW), .NW(NW)) u_sqrt (
    .clk, .rst, .en, .in_valid(v_s), .s(s), .nx(sx), .ny(sy), .nz(sz),
    .out_valid(v_r), .root(root), .zero(zr), .ox(rx), .oy(ry), .oz(rz)
  );

  tun_div #(.NW(NW), .RW(RW), .F(NORMAL_FRAC_BITS)) u_dx (
    .clk, .rst, .en, .in_valid(v_r), .n(rx), .d(root), .zero(zr),
    .out_valid(v_d), .q_out(qx), .zero_out(dz)
  );

  tun_div #(.NW(NW), .RW(RW), .F(NORMAL_FRAC_BITS)) u_dy (
    .clk, .rst, .en, .in_valid(v_r), .n(ry), .d(root), .zero(zr),
    .out_valid(), .q_out(qy), .zero_out()
  );

  tun_div #(.NW(NW), .RW(RW), .F(NORMAL_FRAC_BITS)) u_dz (
    .clk, .rst, .en, .in_valid(v_r), .n(rz), .d(root), .zero(zr),
    .out_valid(), .q_out(qz), .zero_out()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.norm_x <= qx;
      out.norm_y <= qy;
      out.norm_z <= qz;
      out.degenerate <= dz;
    end
  end

  assign out.valid = vout;
endmodule
